/* src/lsbr_pkg.sv */
// Shared types and constants for the 3x3 block LSB reveal core.
// No dependencies; used by lsbr_ctrl, lsbr_store and lsb_block_reveal_core.
package lsbr_pkg;

	localparam int BLK_DIM            = 3;
	localparam int BITS_PER_CH        = 8;
	localparam int CFG_W              = 12;
	localparam int CFG_IDX_W          = 2;
	localparam int DEF_MAX_BLOCK_COLS = 1024;
	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd3;
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	// Where the current pixel sits relative to its block.
	typedef struct packed {
		logic       in_blk;
		logic [2:0] bit_idx;
		logic       last_col;
		logic       last_row;
	} pos_t;

	// Finished hidden pixel leaving the accumulation stage.
	typedef struct packed {
		logic       emit;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_col;
		logic       last_row;
	} hid_t;

endpackage

/* src/lsbr_ctrl.sv */
// Raster position tracking and block decode for the LSB reveal core.
// Holds the image size registers; depends on lsbr_pkg.
module lsbr_ctrl
	import lsbr_pkg::*;
#(
	parameter int MAX_BLOCK_COLS = DEF_MAX_BLOCK_COLS,
	parameter int AW             = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 accept,
	output pos_t                 pos,
	output logic [AW-1:0]        addr
);

	logic [CFG_W-1:0] width_q, height_q;
	logic [CFG_W-1:0] x_q, y_q, x0_q, y0_q, bc_q;
	logic [1:0]       rx_q, ry_q;
	logic [3:0]       bit_w;
	logic             col_ok, row_ok;
	logic             cfg_hit;

	// Block column/row bounds are checked against the block start coordinate,
	// so no division by three is needed.
	always_comb begin
		bit_w  = 4'({2'b00, ry_q}) * 4'(BLK_DIM) + 4'({2'b00, rx_q});
		col_ok = (({1'b0, x0_q} + 13'(BLK_DIM)) <= {1'b0, width_q})
			&& ({1'b0, bc_q} < 13'(MAX_BLOCK_COLS));
		row_ok = ({1'b0, y0_q} + 13'(BLK_DIM)) <= {1'b0, height_q};
		pos.in_blk   = col_ok && row_ok && (bit_w < 4'(BITS_PER_CH));
		pos.bit_idx  = bit_w[2:0];
		pos.last_col = (({1'b0, x0_q} + 13'(2 * BLK_DIM)) > {1'b0, width_q})
			|| (({1'b0, bc_q} + 13'd1) == 13'(MAX_BLOCK_COLS));
		pos.last_row = ({1'b0, y0_q} + 13'(2 * BLK_DIM)) > {1'b0, height_q};
		addr         = bc_q[AW-1:0];
		cfg_hit      = cfg_we && ((cfg_index == REG_IMAGE_WIDTH)
			|| (cfg_index == REG_IMAGE_HEIGHT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			x_q  <= '0;
			y_q  <= '0;
			x0_q <= '0;
			y0_q <= '0;
			bc_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
			// Any register write restarts the frame.
			x_q  <= '0;
			y_q  <= '0;
			x0_q <= '0;
			y0_q <= '0;
			bc_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
		end else if (accept) begin
			if (({1'b0, x_q} + 13'd1) >= {1'b0, width_q}) begin
				x_q  <= '0;
				x0_q <= '0;
				bc_q <= '0;
				rx_q <= '0;
				if (({1'b0, y_q} + 13'd1) >= {1'b0, height_q}) begin
					y_q  <= '0;
					y0_q <= '0;
					ry_q <= '0;
				end else begin
					y_q <= y_q + 12'd1;
					if (ry_q == 2'(BLK_DIM - 1)) begin
						ry_q <= '0;
						y0_q <= y0_q + 12'(BLK_DIM);
					end else begin
						ry_q <= ry_q + 2'd1;
					end
				end
			end else begin
				x_q <= x_q + 12'd1;
				if (rx_q == 2'(BLK_DIM - 1)) begin
					rx_q <= '0;
					x0_q <= x0_q + 12'(BLK_DIM);
					bc_q <= bc_q + 12'd1;
				end else begin
					rx_q <= rx_q + 2'd1;
				end
			end
		end
	end

endmodule

/* src/lsbr_store.sv */
// Per-block-column partial byte memory with read-modify-write stage.
// A one-entry forward covers back-to-back beats on the same block; uses lsbr_pkg.
module lsbr_store
	import lsbr_pkg::*;
#(
	parameter int MAX_BLOCK_COLS = DEF_MAX_BLOCK_COLS,
	parameter int AW             = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  pos_t          pos,
	input  logic [AW-1:0] addr,
	input  logic [2:0]    lsb,
	input  logic          adv,
	output logic          busy,
	output hid_t          hid
);

	localparam int DW = 3 * BITS_PER_CH;

	logic [DW-1:0] mem [MAX_BLOCK_COLS];

	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	pos_t          pos_s1;
	logic [2:0]    lsb_s1;
	logic [DW-1:0] rd_s1;

	logic          wr_vld_q;
	logic [AW-1:0] wr_addr_q;
	logic [DW-1:0] wr_data_q;

	logic [DW-1:0] base, trip, acc;
	logic          wr;

	always_comb begin
		if (wr_vld_q && (wr_addr_q == addr_s1)) begin
			base = wr_data_q;
		end else begin
			base = rd_s1;
		end
		trip = '0;
		trip[pos_s1.bit_idx]                   = lsb_s1[0];
		trip[BITS_PER_CH + pos_s1.bit_idx]     = lsb_s1[1];
		trip[2 * BITS_PER_CH + pos_s1.bit_idx] = lsb_s1[2];
		// The block's first pixel starts a fresh entry.
		acc = ((pos_s1.bit_idx == 3'd0) ? '0 : base) | trip;
		wr  = valid_s1 && adv;
		busy         = valid_s1;
		hid.emit     = valid_s1 && (pos_s1.bit_idx == 3'(BITS_PER_CH - 1));
		hid.blue     = acc[BITS_PER_CH-1:0];
		hid.green    = acc[2*BITS_PER_CH-1:BITS_PER_CH];
		hid.red      = acc[DW-1:2*BITS_PER_CH];
		hid.last_col = pos_s1.last_col;
		hid.last_row = pos_s1.last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wr_vld_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= pos.in_blk;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (wr) begin
				wr_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && pos.in_blk) begin
			addr_s1 <= addr;
			pos_s1  <= pos;
			lsb_s1  <= lsb;
			rd_s1   <= mem[addr];
		end
		if (wr) begin
			mem[addr_s1] <= acc;
			wr_addr_q    <= addr_s1;
			wr_data_q    <= acc;
		end
	end

endmodule

/* src/lsb_block_reveal_core.sv */
// Top level of the 3x3 block LSB reveal core with its output register.
// Instantiates lsbr_ctrl and lsbr_store; uses lsbr_pkg.
//
// Cover pixels enter in raster order at one beat per clock; every pixel is
// taken at once unless a finished hidden pixel waits in the output register
// while the next one is also finishing. A hidden pixel leaves after the eighth
// pixel of its block through the partial byte memory read stage and then the
// output register. The memory holds one 24-bit entry per block column and
// needs no clearing after reset, since each block's first pixel overwrites its
// entry. Configuration writes are taken in any cycle; writes to the width or
// height register restart the frame.
module lsb_block_reveal_core
	import lsbr_pkg::*;
#(
	parameter int MAX_BLOCK_COLS = DEF_MAX_BLOCK_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  logic [7:0]           blue_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           red_in,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [7:0]           blue_out,
	output logic [7:0]           green_out,
	output logic [7:0]           red_out,
	output logic                 row_end,
	output logic                 image_end
);

	localparam int AW = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;

	pos_t          pos;
	logic [AW-1:0] addr;
	hid_t          hid;
	logic          busy, adv, accept, ld_out;
	logic          res_valid_q;

	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;

	// The stage holds only when its finished pixel has nowhere to go.
	assign adv       = !(busy && hid.emit && res_valid_q && res_stall);
	assign pix_stall = !adv;
	assign accept    = pix_valid && adv;
	assign ld_out    = adv && hid.emit;

	lsbr_ctrl #(
		.MAX_BLOCK_COLS(MAX_BLOCK_COLS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.pos(pos),
		.addr(addr)
	);

	lsbr_store #(
		.MAX_BLOCK_COLS(MAX_BLOCK_COLS),
		.AW(AW)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.pos(pos),
		.addr(addr),
		.lsb({red_in[0], green_in[0], blue_in[0]}),
		.adv(adv),
		.busy(busy),
		.hid(hid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ld_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			blue_out  <= hid.blue;
			green_out <= hid.green;
			red_out   <= hid.red;
			row_end   <= hid.last_col;
			image_end <= hid.last_col && hid.last_row;
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (res_valid && res_stall))
		else $error("input stalled while the output register could take a beat");

	a_image_end_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!image_end || row_end))
		else $error("image end flagged on a pixel that does not end its row");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> res_valid)
		else $error("stalled hidden pixel was lost");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for lsb_block_reveal_core: random and directed cover pixels
// against an in-bench model of the 3x3 block LSB reveal, over many image sizes.
// Depends on lsbr_pkg and lsb_block_reveal_core only.
module tb_top;
	import lsbr_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_PIXELS = 1000;
	// Indexes outside the register map; a write there must leave the frame alone.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       row_end;
		logic       image_end;
	} hidden_pixel_t;

	// Tracks the raster position and partial bytes, and holds the hidden
	// pixels still owed by the block.
	class reveal_tracker;
		bit [23:0]     partial_store [DEF_MAX_BLOCK_COLS];
		int            col_pos;
		int            row_pos;
		int            width;
		int            height;
		hidden_pixel_t hidden_due [$];
		int            mismatches;

		function new();
			col_pos = 0;
			row_pos = 0;
			width = int'(RST_IMAGE_WIDTH);
			height = int'(RST_IMAGE_HEIGHT);
			mismatches = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_IMAGE_WIDTH: begin
					width = int'(value);
				end
				REG_IMAGE_HEIGHT: begin
					height = int'(value);
				end
				default: begin
					return;
				end
			endcase
			col_pos = 0;
			row_pos = 0;
		endfunction

		function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
			int            block_cols;
			int            block_rows;
			int            bc;
			int            br;
			int            bit_no;
			bit [23:0]     acc;
			hidden_pixel_t hp;
			block_cols = width / BLK_DIM;
			block_rows = height / BLK_DIM;
			if (block_cols > DEF_MAX_BLOCK_COLS)
				block_cols = DEF_MAX_BLOCK_COLS;
			bc = col_pos / BLK_DIM;
			br = row_pos / BLK_DIM;
			bit_no = (row_pos % BLK_DIM) * BLK_DIM + col_pos % BLK_DIM;
			if (bc < block_cols && br < block_rows && bit_no < BITS_PER_CH) begin
				// The first pixel of a block starts a fresh entry.
				acc = (bit_no == 0) ? 24'd0 : partial_store[bc];
				acc[bit_no]      = acc[bit_no] | b[0];
				acc[8 + bit_no]  = acc[8 + bit_no] | g[0];
				acc[16 + bit_no] = acc[16 + bit_no] | r[0];
				partial_store[bc] = acc;
				if (bit_no == BITS_PER_CH - 1) begin
					hp.blue = acc[7:0];
					hp.green = acc[15:8];
					hp.red = acc[23:16];
					hp.row_end = (bc + 1 == block_cols);
					hp.image_end = (bc + 1 == block_cols) && (br + 1 == block_rows);
					hidden_due.push_back(hp);
				end
			end
			if (col_pos + 1 >= width) begin
				col_pos = 0;
				row_pos = (row_pos + 1 >= height) ? 0 : row_pos + 1;
			end else begin
				col_pos = col_pos + 1;
			end
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s mismatch: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_hidden(logic [7:0] b, logic [7:0] g, logic [7:0] r,
				logic re, logic ie);
			hidden_pixel_t hp;
			if (hidden_due.size() == 0) begin
				$error("hidden pixel %0h/%0h/%0h arrived with none expected", b, g, r);
				mismatches++;
				return;
			end
			hp = hidden_due.pop_front();
			compare_field("blue_out", int'(hp.blue), int'(b));
			compare_field("green_out", int'(hp.green), int'(g));
			compare_field("red_out", int'(hp.red), int'(r));
			compare_field("row_end", int'(hp.row_end), int'(re));
			compare_field("image_end", int'(hp.image_end), int'(ie));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 pix_valid;
	logic                 pix_stall;
	logic [7:0]           blue_in;
	logic [7:0]           green_in;
	logic [7:0]           red_in;
	logic                 res_valid;
	logic                 res_stall;
	logic [7:0]           blue_out;
	logic [7:0]           green_out;
	logic [7:0]           red_out;
	logic                 row_end;
	logic                 image_end;

	reveal_tracker tracker;
	int            cycle_count = 0;
	int            burst_left = 0;
	bit            calm = 0;
	bit            stall_phase = 0;
	int            stall_left = 0;

	lsb_block_reveal_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.blue_out  (blue_out),
		.green_out (green_out),
		.red_out   (red_out),
		.row_end   (row_end),
		.image_end (image_end)
	);

	always #4 clk = ~clk;

	// Results are checked before the pixel beat of the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				tracker.check_hidden(blue_out, green_out, red_out, row_end, image_end);
			if (pix_valid && !pix_stall)
				tracker.note_pixel(blue_in, green_in, red_in);
			if (cfg_valid && cfg_ready)
				tracker.set_register(cfg_index, cfg_data);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver alternates stall and accept runs of random length, and never stalls while calm.
	always @(negedge clk) begin
		if (calm) begin
			res_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_phase = !stall_phase;
				stall_left = stall_phase ? $urandom_range(1, 8) : $urandom_range(1, 12);
			end
			stall_left--;
			res_stall <= stall_phase;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				pix_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		pix_valid <= 1'b1;
		blue_in <= b;
		green_in <= g;
		red_in <= r;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(input int n);
		repeat (n)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Waits until every owed hidden pixel is out and the pipeline has drained, then writes the register.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		pix_valid <= 1'b0;
		while (tracker.hidden_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int w, input int h, input int n);
		write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
		send_random(n);
	endtask

	initial begin
		int w;
		int h;
		int area;
		int n;
		int random_sent;
		tracker = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		pix_valid = 1'b0;
		blue_in = '0;
		green_in = '0;
		red_in = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset size is one block: all ones, then clear blue with alternating green and red low bits
		// (which also crosses the frame wrap), then a third frame under random receiver stalls.
		calm = 1;
		repeat (9)
			send_pixel(8'hFF, 8'hFF, 8'hFF);
		for (int i = 0; i < 9; i++)
			send_pixel(8'h00, 8'(i * 29), 8'hFE | 8'(i & 1));
		calm = 0;
		for (int i = 0; i < 9; i++)
			send_pixel(8'(i[0] ? 8'h01 : 8'hFE), 8'(i[1] ? 8'hFF : 8'h00), 8'(8'h80 >> i));

		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			if ($urandom_range(0, 7) == 0) begin
				w = $urandom_range(0, 5);
				h = $urandom_range(0, 5);
			end else begin
				w = $urandom_range(3, 24);
				h = $urandom_range(3, 15);
			end
			area = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
			n = $urandom_range(1, 3) * area;
			if ($urandom_range(0, 1) == 1)
				n += $urandom_range(0, area - 1);
			calm = ($urandom_range(0, 3) == 0);
			run_phase(w, h, n);
			if (w >= BLK_DIM && h >= BLK_DIM)
				random_sent += n;
			if ($urandom_range(0, 4) == 0) begin
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
				n = $urandom_range(1, area);
				send_random(n);
				if (w >= BLK_DIM && h >= BLK_DIM)
					random_sent += n;
			end
		end

		pix_valid <= 1'b0;
		while (tracker.hidden_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
src/lsbr_pkg.sv
src/lsbr_ctrl.sv
src/lsbr_store.sv
src/lsb_block_reveal_core.sv
bench/tb_top.sv
